// ===== rtl/sds_pkg.sv =====
package sds_pkg;

    // Field widths.
    localparam int CYL_W     = 16;
    localparam int SUM_W     = 22;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;

    // Default store depth.
    localparam int MAX_REQ_DEF = 32;

    // Saturation limit of the movement total.
    localparam logic [SUM_W-1:0] SUM_MAX = 22'h3FFFFF;

    // Largest disk size that still maps to its own end stop.
    localparam logic [CFG_W-1:0] DISK_MAX = 17'd65536;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_UP   = 2'd2;

    // Configuration reset values.
    localparam logic [CYL_W-1:0] START_HEAD_RST = 16'd0;
    localparam logic [CFG_W-1:0] DISK_SIZE_RST  = 17'd200;
    localparam logic             SWEEP_UP_RST   = 1'b1;

    // Input item.
    typedef struct packed {
        logic [CYL_W-1:0] request_cylinder;
        logic             batch_last;
    } t_req;

    // Result item.
    typedef struct packed {
        logic [CYL_W-1:0] visit_cylinder;
        logic             is_end_stop;
        logic [SUM_W-1:0] total_movement;
        logic             seq_last;
    } t_visit;

    // Settled configuration handed to the engine.
    typedef struct packed {
        logic [CYL_W-1:0] start_head;
        logic [CYL_W-1:0] top_cyl;
        logic             sweep_up;
    } t_cfg;

    // Engine states.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // Sweep phases of one batch.
    typedef enum logic [1:0] {
        PH_FIRST,
        PH_END,
        PH_SECOND
    } t_phase;

endpackage

// ===== rtl/sds_store.sv =====
module sds_store #(
    parameter int MAX_REQ = sds_pkg::MAX_REQ_DEF,
    localparam int IW = (MAX_REQ > 1) ? $clog2(MAX_REQ) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [IW-1:0]              i_waddr,
    input  logic [sds_pkg::CYL_W-1:0]  i_wdata,
    input  logic [IW-1:0]              i_raddr,
    output logic [sds_pkg::CYL_W-1:0]  o_rdata
);
    import sds_pkg::*;

    logic [CYL_W-1:0] r_mem [MAX_REQ];
    logic [CYL_W-1:0] r_rdata;

    // Request memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sds_engine.sv =====
module sds_engine #(
    parameter int MAX_REQ = sds_pkg::MAX_REQ_DEF,
    localparam int IW = (MAX_REQ > 1) ? $clog2(MAX_REQ) : 1,
    localparam int CW = $clog2(MAX_REQ + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sds_pkg::t_cfg              i_cfg,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  sds_pkg::t_req              i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output sds_pkg::t_visit            o_out_data,
    output logic                       o_mem_we,
    output logic [IW-1:0]              o_mem_waddr,
    output logic [sds_pkg::CYL_W-1:0]  o_mem_wdata,
    output logic [IW-1:0]              o_mem_raddr,
    input  logic [sds_pkg::CYL_W-1:0]  i_mem_rdata
);
    import sds_pkg::*;

    // A search key orders equal cylinders by their store index.
    localparam int KW = CYL_W + IW;

    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    logic             r_up, n_up;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_n, n_n;
    logic [CW-1:0]    r_served, n_served;
    logic [CW-1:0]    r_addr, n_addr;
    logic             r_rd_vld, n_rd_vld;
    logic             r_rd_last, n_rd_last;
    logic [IW-1:0]    r_rd_idx, n_rd_idx;
    logic             r_best_vld, n_best_vld;
    logic [KW-1:0]    r_best_key, n_best_key;
    logic [KW:0]      r_lo, n_lo;
    logic [KW-1:0]    r_hi, n_hi;
    logic [CYL_W-1:0] r_head, n_head;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic             r_out_vld, n_out_vld;
    t_visit           r_out, n_out;

    logic             in_acc;
    logic             full;
    logic             issue;
    logic             asc;
    logic [KW-1:0]    rd_key;
    logic             cand;
    logic             is_end;
    logic             has_item;
    logic             slot;
    logic             is_last;
    logic [CYL_W-1:0] cyl;
    logic [CYL_W-1:0] delta;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum_new;

    // Handshake and store write side.
    assign in_acc      = i_in_valid && (r_state == ST_LOAD);
    assign full        = (r_count == CW'(MAX_REQ));
    assign o_in_stall  = (r_state != ST_LOAD);
    assign o_mem_we    = in_acc && !full;
    assign o_mem_waddr = r_count[IW-1:0];
    assign o_mem_wdata = i_in_data.request_cylinder;
    assign o_mem_raddr = r_addr[IW-1:0];

    // One store read per cycle during a search pass.
    assign issue = (r_state == ST_SCAN) && (r_addr < r_n);

    // The first phase follows the configured direction, the second runs against it.
    assign asc    = r_up ^ (r_phase == PH_SECOND);
    assign rd_key = {i_mem_rdata, r_rd_idx};

    // Ascending: smallest key at or above the low bound.
    // Descending: largest key below the high bound.
    always_comb begin
        if (asc) begin
            cand = ({1'b0, rd_key} >= r_lo) && (!r_best_vld || (rd_key < r_best_key));
        end else begin
            cand = (rd_key < r_hi) && (!r_best_vld || (rd_key > r_best_key));
        end
    end

    // Next visit and its movement.
    assign is_end   = (r_phase == PH_END);
    assign has_item = is_end || r_best_vld;
    assign slot     = !r_out_vld || !i_out_stall;
    assign cyl      = is_end ? (r_up ? i_cfg.top_cyl : '0) : r_best_key[KW-1 -: CYL_W];
    assign is_last  = is_end ? (r_served == r_n)
                             : ((r_phase == PH_SECOND) && ((r_served + CW'(1)) == r_n));
    assign delta    = (cyl >= r_head) ? (cyl - r_head) : (r_head - cyl);
    assign sum_wide = {1'b0, r_sum} + (SUM_W + 1)'(delta);
    assign sum_new  = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];

    // Next state and datapath updates.
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_up       = r_up;
        n_count    = r_count;
        n_n        = r_n;
        n_served   = r_served;
        n_addr     = r_addr;
        n_rd_vld   = 1'b0;
        n_rd_last  = 1'b0;
        n_rd_idx   = r_addr[IW-1:0];
        n_best_vld = r_best_vld;
        n_best_key = r_best_key;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_head     = r_head;
        n_sum      = r_sum;
        n_out_vld  = r_out_vld && i_out_stall;
        n_out      = r_out;

        // Fold returning read data into the running best key.
        if (r_rd_vld && cand) begin
            n_best_vld = 1'b1;
            n_best_key = rd_key;
        end

        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (!full) begin
                        n_count = r_count + CW'(1);
                    end
                    if (i_in_data.batch_last) begin
                        n_n        = full ? r_count : (r_count + CW'(1));
                        n_count    = '0;
                        n_served   = '0;
                        n_phase    = PH_FIRST;
                        n_up       = i_cfg.sweep_up;
                        n_head     = i_cfg.start_head;
                        n_sum      = '0;
                        n_lo       = {1'b0, i_cfg.start_head, {IW{1'b0}}};
                        n_hi       = {i_cfg.start_head, {IW{1'b0}}};
                        n_addr     = '0;
                        n_best_vld = 1'b0;
                        n_state    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    n_addr    = r_addr + CW'(1);
                    n_rd_vld  = 1'b1;
                    n_rd_last = ((r_addr + CW'(1)) == r_n);
                end
                if (r_rd_vld && r_rd_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!has_item) begin
                    // Nothing left on this side: turn at the end stop after the first sweep, else finish the batch.
                    if (r_phase == PH_FIRST) begin
                        n_phase = PH_END;
                    end else begin
                        n_state = ST_LOAD;
                    end
                end else if (slot) begin
                    n_out_vld            = 1'b1;
                    n_out.visit_cylinder = cyl;
                    n_out.is_end_stop    = is_end;
                    n_out.total_movement = sum_new;
                    n_out.seq_last       = is_last;
                    n_head               = cyl;
                    n_sum                = sum_new;
                    if (is_end) begin
                        n_phase = PH_SECOND;
                    end else begin
                        n_served = r_served + CW'(1);
                        if (asc) begin
                            n_lo = {1'b0, r_best_key} + (KW + 1)'(1);
                        end else begin
                            n_hi = r_best_key;
                        end
                    end
                    n_best_vld = 1'b0;
                    n_addr     = '0;
                    n_state    = is_last ? ST_LOAD : ST_SCAN;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_head    <= '0;
            r_sum     <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
            r_head    <= n_head;
            r_sum     <= n_sum;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_phase    <= n_phase;
        r_up       <= n_up;
        r_n        <= n_n;
        r_served   <= n_served;
        r_addr     <= n_addr;
        r_rd_last  <= n_rd_last;
        r_rd_idx   <= n_rd_idx;
        r_best_vld <= n_best_vld;
        r_best_key <= n_best_key;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/scan_disk_scheduler.sv =====
// Requests load at one item per cycle while the input is open; a non-final item gives no result.
// After the final item of a batch, each request visit takes one full pass over the request
// memory through its single read port, a registered read, then a step to issue the visit;
// output stalls can hold the issue. The end stop takes one more step, to turn. The input
// takes no item until the batch is done.
// Synchronous active-low reset clears control state and configuration; memory is not cleared.
module scan_disk_scheduler #(
    parameter int MAX_REQ = sds_pkg::MAX_REQ_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sds_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sds_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  sds_pkg::t_req                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output sds_pkg::t_visit               o_out_data
);
    import sds_pkg::*;

    localparam int IW = (MAX_REQ > 1) ? $clog2(MAX_REQ) : 1;

    logic [CYL_W-1:0] r_start_head;
    logic [CFG_W-1:0] r_disk_size;
    logic             r_sweep_up;

    logic [CFG_W-1:0] disk_m1;
    t_cfg             cfg;
    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    logic [CYL_W-1:0] mem_wdata;
    logic [IW-1:0]    mem_raddr;
    logic [CYL_W-1:0] mem_rdata;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_head <= START_HEAD_RST;
            r_disk_size  <= DISK_SIZE_RST;
            r_sweep_up   <= SWEEP_UP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_HEAD: r_start_head <= i_cfg_data[CYL_W-1:0];
                CFG_DISK_SIZE:  r_disk_size  <= i_cfg_data;
                CFG_SWEEP_UP:   r_sweep_up   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // High end stop: zero for an empty disk, clamped to the largest cylinder.
    assign disk_m1 = r_disk_size - CFG_W'(1);

    always_comb begin
        cfg.start_head = r_start_head;
        cfg.sweep_up   = r_sweep_up;
        if (r_disk_size == '0) begin
            cfg.top_cyl = '0;
        end else if (r_disk_size > DISK_MAX) begin
            cfg.top_cyl = '1;
        end else begin
            cfg.top_cyl = disk_m1[CYL_W-1:0];
        end
    end

    sds_store #(
        .MAX_REQ (MAX_REQ)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    sds_engine #(
        .MAX_REQ (MAX_REQ)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // The final item of a batch closes the input until scheduling is done.
    a_last_closes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.batch_last) |=> o_in_stall)
        else $error("input still open after the final item of a batch");

    // Writes never land past the end of the request memory.
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (int'(mem_waddr) < MAX_REQ))
        else $error("request memory write out of range");

    // An end stop visit is always one of the two disk ends.
    a_end_stop_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.is_end_stop) |->
        ((o_out_data.visit_cylinder == '0) || (o_out_data.visit_cylinder == cfg.top_cyl)))
        else $error("end stop visit is not a disk end");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import sds_pkg::*;

    // Clock, reset and the driven inputs, all known from time zero.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx     = CFG_START_HEAD;
    logic [CFG_W-1:0]     cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    t_req                 in_data     = '0;
    logic                 out_stall   = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_visit               o_out_data;

    // Items waiting to be offered, and visits the scheduler still owes us.
    t_req   pending_requests [$];
    t_visit pending_visits [$];

    // Shadow of the configuration registers.
    logic [CYL_W-1:0] cfg_start_head = START_HEAD_RST;
    logic [CFG_W-1:0] cfg_disk_size  = DISK_SIZE_RST;
    logic             cfg_sweep_up   = SWEEP_UP_RST;

    // Shadow of the scheduler state.
    logic [CYL_W-1:0] req_store [MAX_REQ_DEF];
    int               req_count = 0;
    logic [CYL_W-1:0] head_pos  = '0;
    int               move_sum  = 0;

    // Traffic shaping, set between phases.
    int send_idle  = 0;
    int recv_stall = 0;
    int hold_req   = 0;
    int hold_seen  = 0;
    int hold_left  = 0;

    int               errors    = 0;
    int               rand_items = 0;
    logic [CYL_W-1:0] last_cyl  = '0;
    t_visit           want_visit;

    scan_disk_scheduler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    // Free-running 10 ns clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run length.
    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

    // Moves the head to one cylinder and returns the visit it produces.
    function automatic t_visit next_visit(input logic [CYL_W-1:0] cyl, input logic stop);
        t_visit vv;
        int     delta;
        delta = (cyl > head_pos) ? int'(cyl - head_pos) : int'(head_pos - cyl);
        move_sum = move_sum + delta;
        if (move_sum > int'(SUM_MAX)) begin
            move_sum = int'(SUM_MAX);
        end
        head_pos = cyl;
        vv.visit_cylinder = cyl;
        vv.is_end_stop    = stop;
        vv.total_movement = move_sum[SUM_W-1:0];
        vv.seq_last       = 1'b0;
        return vv;
    endfunction

    // Stores one accepted request; the final item of a batch schedules the whole batch.
    task automatic predict_request(input t_req r);
        logic [CYL_W-1:0] sorted [MAX_REQ_DEF];
        t_visit           visits [MAX_REQ_DEF + 1];
        logic [CYL_W-1:0] v;
        int               n, i, j, split, top, k;
        t_visit           vv;
        if (req_count < MAX_REQ_DEF) begin
            req_store[req_count] = r.request_cylinder;
            req_count++;
        end
        if (!r.batch_last) begin
            return;
        end
        n = req_count;
        // Insertion sort, ascending.
        for (i = 0; i < n; i++) begin
            v = req_store[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        // A request equal to the start head belongs to the upper side.
        split = 0;
        while (split < n && sorted[split] < cfg_start_head) begin
            split++;
        end
        if (cfg_disk_size == 0) begin
            top = 0;
        end else if (cfg_disk_size > DISK_MAX) begin
            top = 65535;
        end else begin
            top = int'(cfg_disk_size) - 1;
        end
        head_pos = cfg_start_head;
        move_sum = 0;
        k = 0;
        if (cfg_sweep_up) begin
            for (i = split; i < n; i++) begin
                visits[k] = next_visit(sorted[i], 1'b0);
                k++;
            end
            visits[k] = next_visit(top[CYL_W-1:0], 1'b1);
            k++;
            for (i = split; i > 0; i--) begin
                visits[k] = next_visit(sorted[i-1], 1'b0);
                k++;
            end
        end else begin
            for (i = split; i > 0; i--) begin
                visits[k] = next_visit(sorted[i-1], 1'b0);
                k++;
            end
            visits[k] = next_visit('0, 1'b1);
            k++;
            for (i = split; i < n; i++) begin
                visits[k] = next_visit(sorted[i], 1'b0);
                k++;
            end
        end
        for (i = 0; i < k; i++) begin
            vv = visits[i];
            vv.seq_last = (i == k - 1);
            pending_visits.push_back(vv);
        end
        req_count = 0;
    endtask

    // Driver: offers pending items, holding each one until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                predict_request(in_data);
            end
            if (!in_valid || !o_in_stall) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_requests.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each taken visit against the oldest expected one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (pending_visits.size() == 0) begin
                    $display("%0t: unexpected visit %p", $time, o_out_data);
                    errors++;
                end else begin
                    want_visit = pending_visits.pop_front();
                    if (o_out_data.visit_cylinder !== want_visit.visit_cylinder) begin
                        $display("%0t: visit_cylinder expected %0d actual %0d", $time,
                                 want_visit.visit_cylinder, o_out_data.visit_cylinder);
                        errors++;
                    end
                    if (o_out_data.is_end_stop !== want_visit.is_end_stop) begin
                        $display("%0t: is_end_stop expected %0d actual %0d", $time,
                                 want_visit.is_end_stop, o_out_data.is_end_stop);
                        errors++;
                    end
                    if (o_out_data.total_movement !== want_visit.total_movement) begin
                        $display("%0t: total_movement expected %0d actual %0d", $time,
                                 want_visit.total_movement, o_out_data.total_movement);
                        errors++;
                    end
                    if (o_out_data.seq_last !== want_visit.seq_last) begin
                        $display("%0t: seq_last expected %0d actual %0d", $time,
                                 want_visit.seq_last, o_out_data.seq_last);
                        errors++;
                    end
                end
            end
            // A long hold-off, when asked for, overrides the random stalls.
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall);
            end
        end
    end

    task automatic push_item(input logic [CYL_W-1:0] cyl, input logic last);
        t_req r;
        r.request_cylinder = cyl;
        r.batch_last       = last;
        pending_requests.push_back(r);
    endtask

    // Writes one register; only called while the scheduler is idle.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_START_HEAD: cfg_start_head = data[CYL_W-1:0];
            CFG_DISK_SIZE:  cfg_disk_size  = data;
            CFG_SWEEP_UP:   cfg_sweep_up   = data[0];
            default: ;
        endcase
    endtask

    task automatic set_cfg(input int head, input int disk, input int up);
        write_cfg(CFG_START_HEAD, head[CFG_W-1:0]);
        write_cfg(CFG_DISK_SIZE, disk[CFG_W-1:0]);
        write_cfg(CFG_SWEEP_UP, up[CFG_W-1:0]);
    endtask

    // Waits until every item is taken and every visit has come out.
    // The check runs mid-cycle so that it sees the settled driver and monitor state.
    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (pending_requests.size() != 0 || in_valid || pending_visits.size() != 0);
        repeat (40) @(posedge i_clk);
    endtask

    // Picks a request cylinder, biased toward the head, the disk's range, the extreme cylinders and duplicates.
    function automatic logic [CYL_W-1:0] rand_cyl();
        logic [CYL_W-1:0] c;
        case ($urandom_range(5))
            0: c = CYL_W'($urandom);
            1: c = CYL_W'(int'(cfg_start_head) + int'($urandom_range(64)) - 32);
            2: c = cfg_start_head;
            3: c = last_cyl;
            4: c = CYL_W'($urandom % ((cfg_disk_size == 0) ? 1 : int'(cfg_disk_size)));
            default: c = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
        last_cyl = c;
        return c;
    endfunction

    // Queues one batch; mostly small, sometimes large, rarely at or past the store depth.
    task automatic add_batch();
        int n, sel, i;
        sel = $urandom_range(99);
        if (sel < 85) begin
            n = $urandom_range(8, 1);
        end else if (sel < 95) begin
            n = $urandom_range(24, 9);
        end else begin
            n = $urandom_range(MAX_REQ_DEF + 6, MAX_REQ_DEF);
        end
        for (i = 0; i < n; i++) begin
            push_item(rand_cyl(), i == n - 1);
        end
        rand_items += n;
    endtask

    // Sequence of phases.
    initial begin
        int ph, head, disk, phase_items;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: a lone request at the head, then requests at the head, inside the disk and past its end.
        push_item(16'd0, 1'b1);
        push_item(16'hFFFF, 1'b0);
        push_item(16'd0, 1'b0);
        push_item(16'd100, 1'b0);
        push_item(16'd199, 1'b0);
        push_item(16'd200, 1'b1);
        drain();

        // Downward sweep with a zero disk size.
        set_cfg(100, 0, 0);
        push_item(16'd100, 1'b0);
        push_item(16'd50, 1'b0);
        push_item(16'd150, 1'b0);
        push_item(16'hFFFF, 1'b0);
        push_item(16'd0, 1'b1);
        drain();

        // Head at the top cylinder, disk size past the largest one.
        set_cfg(65535, 131071, 1);
        push_item(16'hFFFF, 1'b0);
        push_item(16'd0, 1'b0);
        push_item(16'hFFFF, 1'b0);
        push_item(16'd32768, 1'b1);
        drain();

        // Largest regular disk, sweeping down from cylinder zero.
        set_cfg(0, 65536, 0);
        push_item(16'd0, 1'b0);
        push_item(16'd1, 1'b0);
        push_item(16'd0, 1'b1);
        drain();

        // Random phases, each with its own configuration and traffic shape.
        ph = 0;
        while (rand_items < 380) begin
            case ($urandom_range(3))
                0: head = 0;
                1: head = 65535;
                2: head = $urandom_range(255);
                default: head = $urandom_range(65535);
            endcase
            case ($urandom_range(5))
                0: disk = 0;
                1: disk = 1;
                2: disk = 65536;
                3: disk = 131071;
                4: disk = $urandom_range(300, 1);
                default: disk = $urandom_range(131071);
            endcase
            set_cfg(head, disk, $urandom_range(1));
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 67; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 67; end
                default: begin send_idle = 28; recv_stall = 28; end
            endcase
            // One phase holds the receiver off while several batches queue up.
            if (ph == 4) begin
                send_idle = 0;
                hold_req++;
            end
            phase_items = rand_items + 48;
            while (rand_items < phase_items) begin
                add_batch();
            end
            drain();
            ph++;
        end

        repeat (60) @(posedge i_clk);
        if (errors == 0 && pending_visits.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
